### src/strp_pkg.sv
// Shared types and character constants for the sensor text record parser.
package strp_pkg;

    localparam logic [7:0] CHAR_T     = 8'h74;  // 't'
    localparam logic [7:0] CHAR_P     = 8'h70;  // 'p'
    localparam logic [7:0] CHAR_H     = 8'h68;  // 'h'
    localparam logic [7:0] CHAR_SEMI  = 8'h3B;  // ';'
    localparam logic [7:0] CHAR_COLON = 8'h3A;  // ':'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'

    localparam logic [31:0] TEMP_ROUND = 32'd128;

    localparam logic [1:0] FIELD_TEMP  = 2'd0;
    localparam logic [1:0] FIELD_PRESS = 2'd1;
    localparam logic [1:0] FIELD_HUMID = 2'd2;

    // Parse phases
    localparam logic [1:0] PH_IDLE  = 2'd0;
    localparam logic [1:0] PH_TAG   = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;
    localparam logic [1:0] PH_VALUE = 2'd3;

    localparam logic [1:0] STATUS_OK = 2'd0;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [23:0] temperature_centi;
        logic signed [31:0] pressure_q8;
        logic signed [31:0] humidity_q10;
    } result_t;

    function automatic logic [7:0] tag_for(input logic [1:0] idx);
        logic [7:0] tag;
        case (idx)
            FIELD_TEMP:  tag = CHAR_T;
            FIELD_PRESS: tag = CHAR_P;
            default:     tag = CHAR_H;
        endcase
        return tag;
    endfunction

endpackage

### src/sensor_text_record_parser.sv
// Top level of the sensor text record parser: byte-wise field parse and result buffer.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------------
//  input    | in        | in_valid / in_stall | byte_value, first_of_record
//  result   | out       | out_valid/out_stall | status, temperature_centi, pressure_q8,
//           |           |                     | humidity_q10
//
// One byte request is taken every cycle while in_stall is low; the parse state
// (phase, field, accumulator, sign, holds) is updated at the accept edge by one pass of
// combinational logic. A closing byte registers its result in the output or skid entry.
// The result side has an output register plus one skid entry, so a stalled output
// does not block input until the skid entry fills; in_stall is simply "skid full".
// Asynchronous reset (rst_n low) returns the parser to idle waiting for a first byte.
module sensor_text_record_parser
    import strp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [7:0]         byte_value,
    input  logic               first_of_record,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic signed [23:0] temperature_centi,
    output logic signed [31:0] pressure_q8,
    output logic signed [31:0] humidity_q10
);

    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  field_reg, field_next;
    logic [31:0] acc_reg, acc_next;
    logic        neg_reg, neg_next;
    logic [23:0] temp_hold_reg, temp_hold_next;
    logic [31:0] press_hold_reg, press_hold_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_reg, skid_next;

    logic        accept;
    logic        emit;
    result_t     res;
    logic [1:0]  ph_eff;
    logic [1:0]  fi_eff;
    logic [31:0] acc_eff;
    logic        neg_eff;
    logic [31:0] value;
    logic [31:0] temp_sum;

    assign accept = in_valid && !in_stall;

    // Signed value of the field and the temperature scale (v*5+128)>>8, arithmetic.
    assign value    = neg_eff ? (32'd0 - acc_eff) : acc_eff;
    assign temp_sum = {value[29:0], 2'b00} + value + TEMP_ROUND;

    always_comb
    begin
        // A flagged byte restarts the parse at the temperature tag.
        ph_eff  = first_of_record ? PH_TAG     : phase_reg;
        fi_eff  = first_of_record ? FIELD_TEMP : field_reg;
        acc_eff = first_of_record ? 32'd0      : acc_reg;
        neg_eff = first_of_record ? 1'b0       : neg_reg;

        phase_next      = ph_eff;
        field_next      = fi_eff;
        acc_next        = acc_eff;
        neg_next        = neg_eff;
        temp_hold_next  = temp_hold_reg;
        press_hold_next = press_hold_reg;
        emit            = 1'b0;
        res             = '0;

        case (ph_eff)
            PH_TAG:
            begin
                if (byte_value != tag_for(fi_eff))
                begin
                    // wrong tag: error status is field + 1, payload zero
                    emit       = 1'b1;
                    res.status = fi_eff + 2'd1;
                    phase_next = PH_IDLE;
                    field_next = FIELD_TEMP;
                end
                else
                begin
                    acc_next   = 32'd0;
                    neg_next   = 1'b0;
                    phase_next = PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                phase_next = PH_VALUE;
            end
            PH_VALUE:
            begin
                if (byte_value == CHAR_COLON)
                begin
                    acc_next = 32'd0;
                    neg_next = 1'b0;
                end
                else if (byte_value == CHAR_MINUS)
                begin
                    acc_next = 32'd0;
                    neg_next = 1'b1;
                end
                else if (byte_value == CHAR_SEMI)
                begin
                    acc_next = 32'd0;
                    neg_next = 1'b0;
                    case (fi_eff)
                        FIELD_TEMP:
                        begin
                            temp_hold_next = temp_sum[31:8];
                            field_next     = FIELD_PRESS;
                            phase_next     = PH_TAG;
                        end
                        FIELD_PRESS:
                        begin
                            press_hold_next = value;
                            field_next      = FIELD_HUMID;
                            phase_next      = PH_TAG;
                        end
                        default:
                        begin
                            emit                  = 1'b1;
                            res.status            = STATUS_OK;
                            res.temperature_centi = temp_hold_reg;
                            res.pressure_q8       = press_hold_reg;
                            res.humidity_q10      = value;
                            field_next            = FIELD_TEMP;
                            phase_next            = PH_IDLE;
                        end
                    endcase
                end
                else
                begin
                    // any other byte counts as a digit, wrapping at 32 bits
                    acc_next = {acc_eff[28:0], 3'b000} + {acc_eff[30:0], 1'b0}
                               + {24'd0, byte_value} - {24'd0, CHAR_ZERO};
                end
            end
            default:
            begin
                // idle: unflagged bytes are dropped
            end
        endcase
    end

    // Output register with one skid entry behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (!out_valid_reg || !out_stall)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = accept && emit;
                out_next       = res;
            end
        end
        else if (accept && emit)
        begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_IDLE;
            field_reg      <= FIELD_TEMP;
            acc_reg        <= 32'd0;
            neg_reg        <= 1'b0;
            temp_hold_reg  <= 24'd0;
            press_hold_reg <= 32'd0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg      <= phase_next;
                field_reg      <= field_next;
                acc_reg        <= acc_next;
                neg_reg        <= neg_next;
                temp_hold_reg  <= temp_hold_next;
                press_hold_reg <= press_hold_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign in_stall          = skid_valid_reg;
    assign out_valid         = out_valid_reg;
    assign status            = out_reg.status;
    assign temperature_centi = out_reg.temperature_centi;
    assign pressure_q8       = out_reg.pressure_q8;
    assign humidity_q10      = out_reg.humidity_q10;

endmodule

### tb/strp_tb_pkg.sv
// Scoreboard class for the sensor text record parser testbench: predictor and expected results.
package strp_tb_pkg;

    import strp_pkg::*;

    class record_scoreboard;

        logic [1:0]   field_idx;
        logic [1:0]   phase;
        logic [31:0]  acc;
        logic         neg;
        logic [23:0]  temp_hold;
        logic [31:0]  press_hold;
        result_t      record_q[$];
        int           failures;

        function new();
            field_idx  = FIELD_TEMP;
            phase      = PH_IDLE;
            acc        = '0;
            neg        = 1'b0;
            temp_hold  = '0;
            press_hold = '0;
            failures   = 0;
        endfunction

        function logic [7:0] field_tag(input logic [1:0] idx);
            if (idx == FIELD_TEMP)
                return CHAR_T;
            if (idx == FIELD_PRESS)
                return CHAR_P;
            return CHAR_H;
        endfunction

        // arithmetic shift of the wrapped 32-bit value, kept to 24 bits
        function logic [23:0] to_centi(input logic [31:0] v);
            logic [31:0] scaled;
            logic [31:0] shifted;
            scaled  = v * 32'd5 + TEMP_ROUND;
            shifted = $signed(scaled) >>> 8;
            return shifted[23:0];
        endfunction

        // Returns 0 when the byte is ignored (idle, not flagged first).
        function bit note_request(input logic [7:0] b, input logic first);
            result_t     r;
            logic [31:0] v;
            if (first)
            begin
                field_idx = FIELD_TEMP;
                phase     = PH_TAG;
                acc       = '0;
                neg       = 1'b0;
            end
            case (phase)
                PH_IDLE:
                begin
                    return 1'b0;
                end
                PH_TAG:
                begin
                    if (b != field_tag(field_idx))
                    begin
                        r                   = '0;
                        r.status            = field_idx + 2'd1;
                        record_q.push_back(r);
                        phase               = PH_IDLE;
                        field_idx           = FIELD_TEMP;
                    end
                    else
                    begin
                        acc   = '0;
                        neg   = 1'b0;
                        phase = PH_SKIP;
                    end
                end
                PH_SKIP:
                begin
                    phase = PH_VALUE;
                end
                default:
                begin
                    if (b == CHAR_COLON)
                    begin
                        acc = '0;
                        neg = 1'b0;
                    end
                    else if (b == CHAR_MINUS)
                    begin
                        acc = '0;
                        neg = 1'b1;
                    end
                    else if (b == CHAR_SEMI)
                    begin
                        v   = neg ? (32'd0 - acc) : acc;
                        acc = '0;
                        neg = 1'b0;
                        if (field_idx == FIELD_TEMP)
                        begin
                            temp_hold = to_centi(v);
                            field_idx = FIELD_PRESS;
                            phase     = PH_TAG;
                        end
                        else if (field_idx == FIELD_PRESS)
                        begin
                            press_hold = v;
                            field_idx  = FIELD_HUMID;
                            phase      = PH_TAG;
                        end
                        else
                        begin
                            r.status            = STATUS_OK;
                            r.temperature_centi = temp_hold;
                            r.pressure_q8       = press_hold;
                            r.humidity_q10      = v;
                            record_q.push_back(r);
                            field_idx           = FIELD_TEMP;
                            phase               = PH_IDLE;
                        end
                    end
                    else
                    begin
                        acc = acc * 32'd10 + {24'd0, b} - {24'd0, CHAR_ZERO};
                    end
                end
            endcase
            return 1'b1;
        endfunction

        function void check_result(input result_t got);
            result_t want;
            if (record_q.size() == 0)
            begin
                $error("unexpected result: status %0d", got.status);
                failures++;
                return;
            end
            want = record_q.pop_front();
            if (got.status !== want.status)
            begin
                $error("status: expected %0d, actual %0d", want.status, got.status);
                failures++;
            end
            if (got.temperature_centi !== want.temperature_centi)
            begin
                $error("temperature_centi: expected %0d, actual %0d",
                       want.temperature_centi, got.temperature_centi);
                failures++;
            end
            if (got.pressure_q8 !== want.pressure_q8)
            begin
                $error("pressure_q8: expected %0d, actual %0d",
                       want.pressure_q8, got.pressure_q8);
                failures++;
            end
            if (got.humidity_q10 !== want.humidity_q10)
            begin
                $error("humidity_q10: expected %0d, actual %0d",
                       want.humidity_q10, got.humidity_q10);
                failures++;
            end
        endfunction

        function int pending();
            return record_q.size();
        endfunction

    endclass

endpackage

### tb/sensor_text_record_parser_tb.sv
// Testbench top for the sensor text record parser: directed and random records, random stalls.
module sensor_text_record_parser_tb
    import strp_pkg::*, strp_tb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PER_PHASE = 365;     // counted requests per idling phase
    localparam int CYCLE_LIMIT    = 400000;  // far above the slowest legal run
    localparam int DRAIN_CYCLES   = 20;      // result path is the output register and one skid entry

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [7:0]         byte_value;
    logic               first_of_record;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic signed [23:0] temperature_centi;
    logic signed [31:0] pressure_q8;
    logic signed [31:0] humidity_q10;

    record_scoreboard sb = new();

    int send_idle_pct;   // chance in 100 that the sender skips a cycle
    int recv_idle_pct;   // chance in 100 that the receiver stalls a cycle
    int counted;         // requests the parser actually acted on
    int cycles;

    sensor_text_record_parser u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .byte_value        (byte_value),
        .first_of_record   (first_of_record),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .status            (status),
        .temperature_centi (temperature_centi),
        .pressure_q8       (pressure_q8),
        .humidity_q10      (humidity_q10)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Receiver: random stall; the decision never looks at out_valid.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result monitor. out_stall read here is the pre-edge value, i.e. the one
    // that decided whether this edge accepted the result.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && out_valid && !out_stall)
        begin
            got.status            = status;
            got.temperature_centi = temperature_centi;
            got.pressure_q8       = pressure_q8;
            got.humidity_q10      = humidity_q10;
            sb.check_result(got);
        end
    end

    // One byte request: optional idle cycles first, then hold the payload
    // until an edge with in_stall low takes it.
    task automatic send_request(input logic [7:0] b, input logic f);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        byte_value      <= b;
        first_of_record <= f;
        do
            @(posedge clk);
        while (in_stall);
        if (sb.note_request(b, f))
            counted++;
    endtask

    // Send a string; only its first character may carry the first flag.
    task automatic send_text(input string s, input logic f);
        int i;
        for (i = 0; i < s.len(); i++)
            send_request(s[i], f && (i == 0));
    endtask

    // One random record. Mostly well formed with random values; a share is
    // noise, wrong tags, abandoned records and stray bytes inside values.
    task automatic gen_record();
        int          fld;
        int          n;
        int          k;
        logic [7:0]  good_tag;
        logic [7:0]  tag;
        logic [7:0]  b;
        if ($urandom_range(99) < 8)
        begin
            n = $urandom_range(1, 4);
            repeat (n)
                send_request(8'($urandom_range(255)), $urandom_range(99) < 20);
            return;
        end
        for (fld = 0; fld < 3; fld++)
        begin
            good_tag = (fld == 0) ? CHAR_T : (fld == 1) ? CHAR_P : CHAR_H;
            tag      = good_tag;
            if ($urandom_range(99) < 4)
                tag = 8'($urandom_range(255));
            send_request(tag, fld == 0);
            if (tag != good_tag)
                return;
            // record cut short; the next first byte abandons it
            if ($urandom_range(99) < 3)
                return;
            send_request(($urandom_range(99) < 90) ? CHAR_COLON
                                                   : 8'($urandom_range(255)), 1'b0);
            if ($urandom_range(99) < 30)
                send_request(CHAR_MINUS, 1'b0);
            k = $urandom_range(99);
            // long digit runs wrap the 32-bit accumulator
            n = (k < 70) ? $urandom_range(0, 6) :
                (k < 90) ? $urandom_range(7, 10) : $urandom_range(11, 14);
            repeat (n)
            begin
                k = $urandom_range(99);
                if (k < 3)
                    b = 8'($urandom_range(255));
                else if (k < 5)
                    b = CHAR_COLON;
                else if (k < 7)
                    b = CHAR_MINUS;
                else
                    b = CHAR_ZERO + 8'($urandom_range(9));
                send_request(b, 1'b0);
            end
            send_request(CHAR_SEMI, 1'b0);
        end
    endtask

    initial
    begin
        int ph;
        rst_n           <= 1'b0;
        in_valid        <= 1'b0;
        byte_value      <= '0;
        first_of_record <= 1'b0;
        out_stall       <= 1'b0;
        cycles          <= 0;
        counted         = 0;
        send_idle_pct   = 7;
        recv_idle_pct   = 82;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part.
        send_request(8'hFF, 1'b0);            // idle byte after reset, ignored
        send_text("p", 1'b1);                 // wrong temperature tag
        send_text("t:1", 1'b1);               // abandoned by the next first byte
        send_text("t", 1'b1);                 // skip byte is not a colon here,
        send_request(8'h00, 1'b0);            // colon clears mid-value,
        send_text("9:7;p:-;h:", 1'b0);        // minus zero,
        send_request(8'hFF, 1'b0);            // non-digit adds byte - 48
        send_text(";", 1'b0);
        send_text("t:;x", 1'b1);              // wrong pressure tag
        send_text("t:;p:;x", 1'b1);           // wrong humidity tag
        send_text("t:-4294967295;p:2147483648;h:4294967295;", 1'b1);

        // Random part, three idling phases.
        for (ph = 0; ph < 3; ph++)
        begin
            if (ph == 1)
            begin
                send_idle_pct = 82;
                recv_idle_pct = 7;
            end
            else if (ph == 2)
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            while (counted < (ph + 1) * RAND_PER_PHASE + 40)
                gen_record();
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.failures == 0 && sb.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### filelist.f
src/strp_pkg.sv
src/sensor_text_record_parser.sv
tb/strp_tb_pkg.sv
tb/sensor_text_record_parser_tb.sv
